// ===== rtl/pft_pkg.sv =====
// Shared constants and types for the polygon fan triangulator.
`default_nettype none

package pft_pkg;

    localparam int MAX_POLY_SIZE_DEF = 16;
    localparam int INDEX_BITS_DEF    = 24;
    localparam int MIN_POLY          = 3;
    localparam int CFG_BITS          = 5;
    localparam int COUNT_BITS        = 32;

    localparam logic [CFG_BITS-1:0]   POLY_SIZE_RESET = 5'd4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX       = {COUNT_BITS{1'b1}};

    // Buffer bank handed back by the emitter when its polygon is finished.
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

`default_nettype wire

// ===== rtl/pft_queue.sv =====
// Two-entry job queue between the index collector and the triangle emitter.
`default_nettype none

module pft_queue
    import pft_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && not_empty) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push && !full, pop && not_empty})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pft_front.sv =====
// Index collector: holds the size register, fills a buffer bank and queues closed polygons.
`default_nettype none

module pft_front
    import pft_pkg::*;
#(
    parameter int MAX_POLY_SIZE = MAX_POLY_SIZE_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    localparam int FW = $clog2(MAX_POLY_SIZE),
    localparam int SW = $clog2(MAX_POLY_SIZE + 1),
    localparam int JW = INDEX_BITS + SW + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_BITS-1:0]   cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [INDEX_BITS-1:0] vertex_index,
    output logic                       q_push,
    output logic [JW-1:0]              q_data,
    input  wire logic                  q_full,
    output logic                       wr_en,
    output logic [FW:0]                wr_addr,
    output logic [INDEX_BITS-1:0]      wr_data,
    input  wire rel_t                  rel
);

    localparam int PW = (SW > CFG_BITS) ? SW : CFG_BITS;

    logic [CFG_BITS-1:0] poly_reg;
    logic [FW-1:0]       fill_reg, fill_next;
    logic                bank_reg, bank_next;
    logic [1:0]          busy_reg, busy_next;
    logic [PW-1:0]       poly_ext;
    logic [SW-1:0]       eff_size;
    logic                accept;
    logic                closing;

    assign cfg_ready = 1'b1;
    assign poly_ext  = PW'(poly_reg);

    // Clamp the configured size into MIN_POLY..MAX_POLY_SIZE.
    always_comb begin
        if (poly_ext < PW'(MIN_POLY)) begin
            eff_size = SW'(MIN_POLY);
        end else if (poly_ext > PW'(MAX_POLY_SIZE)) begin
            eff_size = SW'(MAX_POLY_SIZE);
        end else begin
            eff_size = SW'(poly_ext);
        end
    end

    assign s_tready = !busy_reg[bank_reg] && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign closing  = !(SW'(fill_reg) < (eff_size - SW'(1)));

    assign wr_en   = accept && !closing;
    assign wr_addr = {bank_reg, fill_reg};
    assign wr_data = vertex_index;

    assign q_push = accept && closing;
    assign q_data = {bank_reg, eff_size, vertex_index};

    always_comb begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept) begin
            if (closing) begin
                fill_next           = '0;
                bank_next           = ~bank_reg;
                busy_next[bank_reg] = 1'b1;
            end else begin
                fill_next = fill_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= POLY_SIZE_RESET;
            fill_reg <= '0;
            bank_reg <= 1'b0;
            busy_reg <= 2'b00;
        end else begin
            if (cfg_valid && cfg_ready) begin
                poly_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pft_back.sv =====
// Emitter: walks a buffered polygon, drops degenerate triangles if size>3, drives the output.
`default_nettype none

module pft_back
    import pft_pkg::*;
#(
    parameter int MAX_POLY_SIZE = MAX_POLY_SIZE_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    localparam int FW = $clog2(MAX_POLY_SIZE),
    localparam int SW = $clog2(MAX_POLY_SIZE + 1),
    localparam int JW = INDEX_BITS + SW + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  job_valid,
    input  wire logic [JW-1:0]         job_data,
    output logic                       job_pop,
    input  wire logic                  wr_en,
    input  wire logic [FW:0]           wr_addr,
    input  wire logic [INDEX_BITS-1:0] wr_data,
    output rel_t                       rel,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [INDEX_BITS-1:0]      tri_first,
    output logic [INDEX_BITS-1:0]      tri_second,
    output logic [INDEX_BITS-1:0]      tri_apex,
    output logic                       last_of_polygon,
    output logic [COUNT_BITS-1:0]      triangle_number
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    logic [INDEX_BITS-1:0] mem [2**(FW+1)];

    state_t                state_reg, state_next;
    logic [FW-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                  dv_reg, dv_next;
    logic [FW-1:0]         dpos_reg, dpos_next;
    logic [INDEX_BITS-1:0] prev_reg, prev_next;
    logic [INDEX_BITS-1:0] rdata_reg;
    logic [INDEX_BITS-1:0] apex_reg, apex_next;
    logic [SW-1:0]         size_reg, size_next;
    logic                  bank_reg, bank_next;
    logic                  hold_vld_reg, hold_vld_next;
    logic [INDEX_BITS-1:0] hold_a_reg, hold_a_next;
    logic [INDEX_BITS-1:0] hold_b_reg, hold_b_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  m_valid_reg, m_valid_next;
    logic [INDEX_BITS-1:0] m_first_reg, m_second_reg, m_apex_reg;
    logic                  m_last_reg;

    logic [SW-1:0] size_m2;
    logic          out_free;
    logic          issue;
    logic          cand;
    logic          keep;
    logic          last_cand;
    logic          push_mid;
    logic          stall;
    logic          adv;
    logic          push_final;
    logic          done;
    logic          load_out;

    assign size_m2   = size_reg - SW'(2);
    assign out_free  = !m_valid_reg || m_tready;
    assign issue     = (state_reg == ST_SCAN) && (SW'(rd_cnt_reg) <= size_m2);
    assign cand      = (state_reg == ST_SCAN) && dv_reg && (dpos_reg != '0);
    assign keep      = (size_reg == SW'(MIN_POLY))
                    || !((prev_reg == rdata_reg) || (prev_reg == apex_reg)
                         || (rdata_reg == apex_reg));
    assign last_cand = dv_reg && (SW'(dpos_reg) == size_m2);

    // A kept triangle pushes out the one held before it; hold if the output is full.
    assign push_mid   = cand && keep && hold_vld_reg;
    assign stall      = push_mid && !out_free;
    assign adv        = (state_reg == ST_SCAN) && !stall;
    assign push_final = (state_reg == ST_FLUSH) && hold_vld_reg && out_free;
    assign done       = (state_reg == ST_FLUSH) && (!hold_vld_reg || out_free);
    assign load_out   = (adv && push_mid) || push_final;

    assign job_pop   = (state_reg == ST_IDLE) && job_valid;
    assign rel.valid = done;
    assign rel.bank  = bank_reg;

    always_comb begin
        state_next    = state_reg;
        rd_cnt_next   = rd_cnt_reg;
        dv_next       = dv_reg;
        dpos_next     = dpos_reg;
        prev_next     = prev_reg;
        apex_next     = apex_reg;
        size_next     = size_reg;
        bank_next     = bank_reg;
        hold_vld_next = hold_vld_reg;
        hold_a_next   = hold_a_reg;
        hold_b_next   = hold_b_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    apex_next     = job_data[INDEX_BITS-1:0];
                    size_next     = job_data[INDEX_BITS +: SW];
                    bank_next     = job_data[JW-1];
                    rd_cnt_next   = '0;
                    dv_next       = 1'b0;
                    hold_vld_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (adv) begin
                    if (issue) begin
                        rd_cnt_next = rd_cnt_reg + FW'(1);
                    end
                    dv_next   = issue;
                    dpos_next = rd_cnt_reg;
                    if (dv_reg) begin
                        prev_next = rdata_reg;
                    end
                    if (cand && keep) begin
                        hold_vld_next = 1'b1;
                        hold_a_next   = prev_reg;
                        hold_b_next   = rdata_reg;
                    end
                    if (last_cand) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (done) begin
                    hold_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        total_next = total_reg;
        if (load_out && (total_reg != COUNT_MAX)) begin
            total_next = total_reg + COUNT_BITS'(1);
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dv_reg       <= 1'b0;
            hold_vld_reg <= 1'b0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dv_reg       <= dv_next;
            hold_vld_reg <= hold_vld_next;
            total_reg    <= total_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_cnt_reg <= rd_cnt_next;
        dpos_reg   <= dpos_next;
        prev_reg   <= prev_next;
        apex_reg   <= apex_next;
        size_reg   <= size_next;
        bank_reg   <= bank_next;
        hold_a_reg <= hold_a_next;
        hold_b_reg <= hold_b_next;
        if (load_out) begin
            m_first_reg  <= hold_a_reg;
            m_second_reg <= hold_b_reg;
            m_apex_reg   <= apex_reg;
            m_last_reg   <= push_final;
        end
    end

    // Index buffer, two banks; read data holds while the scan is stalled.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (adv && issue) begin
            rdata_reg <= mem[{bank_reg, rd_cnt_reg}];
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign tri_first       = m_first_reg;
    assign tri_second      = m_second_reg;
    assign tri_apex        = m_apex_reg;
    assign last_of_polygon = m_last_reg;
    assign triangle_number = total_reg;

endmodule

`default_nettype wire

// ===== rtl/polygon_fan_triangulator.sv =====
// Top level of the polygon fan triangulator: collector, job queue and emitter.
//
//   channel  direction  payload
//   cfg      in         cfg_data: poly_size
//   s_       in         s_tdata: vertex_index
//   m_       out        m_tdata: tri_first, tri_second, tri_apex, triangle_number;
//                       m_tlast: last_of_polygon
//
// The collector takes one index word per cycle while its buffer bank is free.
// Two banks let the next polygon fill while the emitter walks the previous one;
// the emitter takes the job, reads the buffered indices through its single buffer
// read port (one index per cycle while the output does not stall it), then drains
// the last kept triangle.
// Reset (synchronous, aresetn low) empties both sides, clears the triangle count
// and sets poly_size to 4. m_tready low stalls the emitter when a kept triangle
// waits on a held output word; s_tready drops while both banks hold unfinished polygons.
`default_nettype none

module polygon_fan_triangulator
    import pft_pkg::*;
#(
    parameter int MAX_POLY_SIZE = MAX_POLY_SIZE_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [CFG_BITS-1:0]                 cfg_data,   // poly_size
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((INDEX_BITS+7)/8)*8-1:0]     s_tdata,    // vertex_index
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // tri_first, tri_second, tri_apex, triangle_number
    output logic [((3*INDEX_BITS+COUNT_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                     m_tlast     // last_of_polygon
);

    localparam int FW  = $clog2(MAX_POLY_SIZE);
    localparam int SW  = $clog2(MAX_POLY_SIZE + 1);
    localparam int JW  = INDEX_BITS + SW + 1;
    localparam int ODW = ((3*INDEX_BITS+COUNT_BITS+7)/8)*8;

    logic                  q_push;
    logic [JW-1:0]         q_push_data;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_not_empty;
    logic [JW-1:0]         q_pop_data;
    logic                  wr_en;
    logic [FW:0]           wr_addr;
    logic [INDEX_BITS-1:0] wr_data;
    rel_t                  rel;
    logic [INDEX_BITS-1:0] tri_first;
    logic [INDEX_BITS-1:0] tri_second;
    logic [INDEX_BITS-1:0] tri_apex;
    logic [COUNT_BITS-1:0] triangle_number;

    pft_front #(
        .MAX_POLY_SIZE (MAX_POLY_SIZE),
        .INDEX_BITS    (INDEX_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .vertex_index (s_tdata[INDEX_BITS-1:0]),
        .q_push       (q_push),
        .q_data       (q_push_data),
        .q_full       (q_full),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rel          (rel)
    );

    pft_queue #(
        .WIDTH (JW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    pft_back #(
        .MAX_POLY_SIZE (MAX_POLY_SIZE),
        .INDEX_BITS    (INDEX_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (q_not_empty),
        .job_data        (q_pop_data),
        .job_pop         (q_pop),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rel             (rel),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .tri_first       (tri_first),
        .tri_second      (tri_second),
        .tri_apex        (tri_apex),
        .last_of_polygon (m_tlast),
        .triangle_number (triangle_number)
    );

    // Pack the output word, first field in the low bits, zero padded to whole bytes.
    assign m_tdata = ODW'({triangle_number, tri_apex, tri_second, tri_first});

endmodule

`default_nettype wire
